// File: sv/fdr_pkg.sv
package fdr_pkg;

    localparam int COS_W = 16;
    localparam int IOR_W = 15;
    localparam int REFL_W = 16;

    localparam int A_W = 15;
    localparam int B_W = 17;
    localparam int AA_W = 29;
    localparam int BB_W = 34;
    localparam int BB_LO_W = 17;
    localparam int PP_W = AA_W + BB_LO_W;
    localparam int PROD_W = 63;
    localparam int RAD_W = 62;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W = ROOT_W + 2;
    localparam int CAND_W = REM_W + 2;
    localparam int X_W = 49;
    localparam int D_W = X_W + 1;
    localparam int FRAC_W = 20;
    localparam int Q_W = FRAC_W + 1;
    localparam int SQ_W = 2 * Q_W;
    localparam int SUM_W = SQ_W + 1;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS = FRAC_W;
    localparam int LATENCY = 4 + SQRT_STEPS + 2 + DIV_STEPS + 2;

    localparam logic [A_W-1:0] ONE_Q14 = A_W'(16384);
    localparam logic [REFL_W-1:0] ONE_Q15 = REFL_W'(32768);
    localparam logic [IOR_W-1:0] MIN_IOR = IOR_W'(1024);
    localparam logic [AA_W-1:0] ONE_SQ = AA_W'(1) << 28;
    localparam logic [PROD_W-1:0] ONE_QUAD = PROD_W'(1) << 56;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << 25;

    typedef struct packed {
        logic from_in;
        logic tir;
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
        logic [BB_W-1:0] bb;
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } sqrt_stage_t;

    typedef struct packed {
        logic tir;
        logic zero1;
        logic full1;
        logic zero2;
        logic full2;
        logic [D_W-1:0] d1;
        logic [D_W-1:0] rem1;
        logic [FRAC_W-1:0] q1;
        logic [D_W-1:0] d2;
        logic [D_W-1:0] rem2;
        logic [FRAC_W-1:0] q2;
    } div_stage_t;

endpackage

// File: sv/fresnel_dielectric_reflectance.sv
// Channel   Ports                                   Handshake
// request   incident_cosine, relative_ior          start, accepted when busy is low
// result    reflectance, total_internal            done, one cycle, no back pressure
//
// A request may enter on every cycle; busy is never raised.
// Each result passes through the input registers, the 31-step square root
// pipeline, the 20-step quotient pipeline and the squaring and output registers.
// Reset clears only the valid bits of every stage.
// The receiver cannot stall, so nothing ever waits in the pipeline.
module fresnel_dielectric_reflectance (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [fdr_pkg::COS_W-1:0] incident_cosine,
    input  logic [fdr_pkg::IOR_W-1:0]   relative_ior,
    output logic                        done,
    output logic [fdr_pkg::REFL_W-1:0]  reflectance,
    output logic                        total_internal
);
    import fdr_pkg::*;

    logic [COS_W-1:0] raw_c;
    logic [COS_W-1:0] mag_c;
    logic [A_W-1:0] a_in;
    logic [IOR_W-1:0] e_in;

    logic v1_reg, v2_reg, v3_reg;
    logic in1_reg, in2_reg, in3_reg;
    logic [A_W-1:0] a1_reg, a2_reg, a3_reg;
    logic [B_W-1:0] b1_reg, b2_reg, b3_reg;
    logic [AA_W-1:0] aa2_reg;
    logic [BB_W-1:0] bb2_reg, bb3_reg;
    logic tir3_reg;
    logic [BB_W-1:0] rbase3_reg;
    logic [PP_W-1:0] plo3_reg, phi3_reg;

    logic [AA_W-1:0] d_sq;
    logic [BB_W:0] aabb_sum;
    logic [PROD_W-1:0] prod;

    sqrt_stage_t sq_reg [0:SQRT_STEPS];
    sqrt_stage_t sq_next [1:SQRT_STEPS];
    sqrt_stage_t sq_first;
    logic [SQRT_STEPS:0] sqv_reg;

    logic v5_reg, tir5_reg;
    logic [X_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [X_W-1:0] x1_next, y1_next, x2_next, y2_next;
    sqrt_stage_t sq_last;

    div_stage_t dv_reg [0:DIV_STEPS];
    div_stage_t dv_next [1:DIV_STEPS];
    div_stage_t dv_first;
    logic [DIV_STEPS:0] dvv_reg;

    logic vq_reg, tirq_reg;
    logic [SQ_W-1:0] sq1_reg, sq2_reg;
    logic [Q_W-1:0] qf1, qf2;
    logic [SUM_W-1:0] sum_rnd;
    logic [SUM_W-27:0] refl_full;

    logic done_reg, total_internal_reg;
    logic [REFL_W-1:0] reflectance_reg;

    assign busy = 1'b0;

    always_comb
    begin
        raw_c = incident_cosine;
        mag_c = raw_c[COS_W-1] ? (~raw_c + COS_W'(1)) : raw_c;
        a_in = (mag_c > COS_W'(ONE_Q14)) ? ONE_Q14 : mag_c[A_W-1:0];
        e_in = (relative_ior < MIN_IOR) ? MIN_IOR : relative_ior;
    end

    always_comb
    begin
        d_sq = ONE_SQ - aa2_reg;
        aabb_sum = (BB_W+1)'(aa2_reg) + (BB_W+1)'(bb2_reg);
        prod = (PROD_W'(phi3_reg) << BB_LO_W) + PROD_W'(plo3_reg);
        sq_first.from_in = in3_reg;
        sq_first.a = a3_reg;
        sq_first.b = b3_reg;
        sq_first.bb = bb3_reg;
        sq_first.rem = '0;
        sq_first.root = '0;
        if (in3_reg)
        begin
            sq_first.tir = (prod >= ONE_QUAD);
            sq_first.rad = RAD_W'(ONE_QUAD - prod);
        end
        else
        begin
            sq_first.tir = tir3_reg;
            sq_first.rad = {rbase3_reg, 28'b0};
        end
    end

    always_comb
    begin
        logic [CAND_W-1:0] cand;
        logic [CAND_W-1:0] trial;
        for (int j = 1; j <= SQRT_STEPS; j++)
        begin
            sq_next[j] = sq_reg[j-1];
            cand = {sq_reg[j-1].rem, sq_reg[j-1].rad[RAD_W-1 -: 2]};
            trial = CAND_W'({sq_reg[j-1].root, 2'b01});
            sq_next[j].rad = {sq_reg[j-1].rad[RAD_W-3:0], 2'b00};
            if (cand >= trial)
            begin
                sq_next[j].rem = REM_W'(cand - trial);
                sq_next[j].root = {sq_reg[j-1].root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_next[j].rem = REM_W'(cand);
                sq_next[j].root = {sq_reg[j-1].root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        sq_last = sq_reg[SQRT_STEPS];
        if (sq_last.from_in)
        begin
            x1_next = X_W'({sq_last.a, 28'b0});
            y1_next = X_W'(sq_last.b * sq_last.root);
            x2_next = X_W'(sq_last.b * sq_last.a);
        end
        else
        begin
            x1_next = X_W'(sq_last.bb * sq_last.a);
            y1_next = X_W'({sq_last.root, 14'b0});
            x2_next = X_W'({sq_last.a, 14'b0});
        end
        y2_next = X_W'(sq_last.root);
    end

    always_comb
    begin
        logic [D_W-1:0] n1, n2;
        n1 = (x1_reg >= y1_reg) ? D_W'(x1_reg - y1_reg) : D_W'(y1_reg - x1_reg);
        n2 = (x2_reg >= y2_reg) ? D_W'(x2_reg - y2_reg) : D_W'(y2_reg - x2_reg);
        dv_first.tir = tir5_reg;
        dv_first.d1 = D_W'(x1_reg) + D_W'(y1_reg);
        dv_first.d2 = D_W'(x2_reg) + D_W'(y2_reg);
        dv_first.zero1 = (dv_first.d1 == '0);
        dv_first.zero2 = (dv_first.d2 == '0);
        dv_first.full1 = (n1 >= dv_first.d1);
        dv_first.full2 = (n2 >= dv_first.d2);
        dv_first.rem1 = n1;
        dv_first.rem2 = n2;
        dv_first.q1 = '0;
        dv_first.q2 = '0;
    end

    always_comb
    begin
        logic [D_W:0] t1, t2;
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            dv_next[j] = dv_reg[j-1];
            t1 = {dv_reg[j-1].rem1, 1'b0};
            t2 = {dv_reg[j-1].rem2, 1'b0};
            if (t1 >= {1'b0, dv_reg[j-1].d1})
            begin
                dv_next[j].rem1 = D_W'(t1 - {1'b0, dv_reg[j-1].d1});
                dv_next[j].q1 = {dv_reg[j-1].q1[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                dv_next[j].rem1 = D_W'(t1);
                dv_next[j].q1 = {dv_reg[j-1].q1[FRAC_W-2:0], 1'b0};
            end
            if (t2 >= {1'b0, dv_reg[j-1].d2})
            begin
                dv_next[j].rem2 = D_W'(t2 - {1'b0, dv_reg[j-1].d2});
                dv_next[j].q2 = {dv_reg[j-1].q2[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                dv_next[j].rem2 = D_W'(t2);
                dv_next[j].q2 = {dv_reg[j-1].q2[FRAC_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (dv_reg[DIV_STEPS].zero1)
            qf1 = '0;
        else if (dv_reg[DIV_STEPS].full1)
            qf1 = Q_ONE;
        else
            qf1 = Q_W'(dv_reg[DIV_STEPS].q1);
        if (dv_reg[DIV_STEPS].zero2)
            qf2 = '0;
        else if (dv_reg[DIV_STEPS].full2)
            qf2 = Q_ONE;
        else
            qf2 = Q_W'(dv_reg[DIV_STEPS].q2);
        sum_rnd = SUM_W'(sq1_reg) + SUM_W'(sq2_reg) + ROUND_HALF;
        refl_full = sum_rnd[SUM_W-1:26];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            sqv_reg <= '0;
            v5_reg <= 1'b0;
            dvv_reg <= '0;
            vq_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            sqv_reg <= {sqv_reg[SQRT_STEPS-1:0], v3_reg};
            v5_reg <= sqv_reg[SQRT_STEPS];
            dvv_reg <= {dvv_reg[DIV_STEPS-1:0], v5_reg};
            vq_reg <= dvv_reg[DIV_STEPS];
            done_reg <= vq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in1_reg <= raw_c[COS_W-1];
        a1_reg <= a_in;
        b1_reg <= {e_in, 2'b00};

        in2_reg <= in1_reg;
        a2_reg <= a1_reg;
        b2_reg <= b1_reg;
        aa2_reg <= AA_W'(a1_reg * a1_reg);
        bb2_reg <= BB_W'(b1_reg * b1_reg);

        in3_reg <= in2_reg;
        a3_reg <= a2_reg;
        b3_reg <= b2_reg;
        bb3_reg <= bb2_reg;
        tir3_reg <= (aabb_sum <= (BB_W+1)'(ONE_SQ));
        rbase3_reg <= BB_W'(aabb_sum - (BB_W+1)'(ONE_SQ));
        plo3_reg <= PP_W'(d_sq * bb2_reg[BB_LO_W-1:0]);
        phi3_reg <= PP_W'(d_sq * bb2_reg[BB_W-1:BB_LO_W]);

        sq_reg[0] <= sq_first;
        for (int j = 1; j <= SQRT_STEPS; j++)
        begin
            sq_reg[j] <= sq_next[j];
        end

        tir5_reg <= sq_last.tir;
        x1_reg <= x1_next;
        y1_reg <= y1_next;
        x2_reg <= x2_next;
        y2_reg <= y2_next;

        dv_reg[0] <= dv_first;
        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            dv_reg[j] <= dv_next[j];
        end

        tirq_reg <= dv_reg[DIV_STEPS].tir;
        sq1_reg <= qf1 * qf1;
        sq2_reg <= qf2 * qf2;

        total_internal_reg <= tirq_reg;
        if (tirq_reg || refl_full > (SUM_W-26)'(ONE_Q15))
            reflectance_reg <= ONE_Q15;
        else
            reflectance_reg <= REFL_W'(refl_full);
    end

    assign done = done_reg;
    assign reflectance = reflectance_reg;
    assign total_internal = total_internal_reg;

endmodule

// File: sv/fdr_checker.sv
module fdr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [fdr_pkg::REFL_W-1:0]  reflectance,
    input logic                        total_internal
);
    import fdr_pkg::*;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after request");

    a_tir_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && total_internal) |-> (reflectance == ONE_Q15))
        else $error("total internal reflection without full reflectance");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (reflectance <= ONE_Q15))
        else $error("reflectance above one");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !busy)
        else $error("pipeline refused a request");

endmodule

bind fresnel_dielectric_reflectance fdr_checker u_fdr_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .reflectance(reflectance),
    .total_internal(total_internal)
);
